// ===== sv/futex_wait_queue_table_core_macros.svh =====
// assertion macros used by the checker file of the futex wait queue core
// needs clk and rst_n in the scope where the macros are used
`ifndef FUTEX_WAIT_QUEUE_TABLE_CORE_MACROS_SVH
`define FUTEX_WAIT_QUEUE_TABLE_CORE_MACROS_SVH

// same-cycle implication
`define FWQ_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("futex wait queue assertion failed");

// next-cycle implication
`define FWQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("futex wait queue assertion failed");

`endif

// ===== sv/fwq_pkg.sv =====
// package of the futex wait queue core: hash constants, codes and widths
// used by the top level and the checker, depends on nothing
`default_nettype none

package fwq_pkg;

  localparam int HASH_BUCKETS_DEF     = 64;
  localparam int SLOTS_PER_BUCKET_DEF = 8;

  localparam logic [63:0] FNV_BASIS = 64'hCBF29CE484222325;
  localparam logic [31:0] FNV_P_LO  = 32'h000001B3;
  localparam logic [31:0] FNV_P_HI  = 32'h00000100;

  localparam int WOKEN_CAP = 8;
  localparam int ADDR_W    = 64;
  localparam int SPACE_W   = 52;
  localparam int TID_W     = 16;
  localparam int ENTRY_W   = ADDR_W + SPACE_W + TID_W;
  localparam int IN_DATA_W = 216;
  localparam int OUT_DATA_W = 24;

  typedef enum logic [1:0] {
    KIND_STATUS = 2'd0,
    KIND_WOKEN  = 2'd1,
    KIND_TOTAL  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    WS_BLOCKED  = 2'd0,
    WS_FAULT    = 2'd1,
    WS_MISMATCH = 2'd2,
    WS_NOROOM   = 2'd3
  } wait_status_t;

endpackage

`default_nettype wire

// ===== sv/futex_wait_queue_table_core.sv =====
// top level of the futex wait queue core: sequencer, hash steps, bucket tables
// depends on fwq_pkg, fwq_ram and fwq_mul
//
// in_* takes one wait or wake per transfer (in_tuser = func), out_* returns
// the results; every result of an item but the final one has out_tlast low.
// a wait returns one status; a wake returns one result per released waiter,
// newest first, then the total.
// the fnv hash runs on one shared 32x32 multiplier in four
// products, then the bucket fill is read; a wait then returns its
// status and the next item is taken after that result is registered.
// a wake reads the entry ram once per scanned slot, then runs the
// compaction pass over every filled slot of the bucket.
// in_tready is high only while the sequencer is idle; one item at a time.
// after reset a clearing pass zeroes the fill table, during which in_tready
// stays low.
// a stalled receiver holds the result register and the sequencer waits.
`default_nettype none

module futex_wait_queue_table_core #(
  parameter int HASH_BUCKETS     = fwq_pkg::HASH_BUCKETS_DEF,
  parameter int SLOTS_PER_BUCKET = fwq_pkg::SLOTS_PER_BUCKET_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // address, space_root, thread_id, expected_value, observed_value,
  // read_fault, wake_limit, zero fill
  input  wire logic [fwq_pkg::IN_DATA_W-1:0]   in_tdata,
  // func
  input  wire logic                            in_tuser,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // wait_status, woken_thread, woken_total, zero fill
  output logic      [fwq_pkg::OUT_DATA_W-1:0]  out_tdata,
  // result_kind
  output logic      [1:0]                      out_tuser,
  output logic                                 out_tlast
);

  import fwq_pkg::*;

  localparam int BW = (HASH_BUCKETS > 1) ? $clog2(HASH_BUCKETS) : 1;
  localparam int SW = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
  localparam int FW = $clog2(SLOTS_PER_BUCKET + 1);
  localparam int DEPTH = HASH_BUCKETS * SLOTS_PER_BUCKET;
  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_H0, S_M1, S_M2, S_M3, S_M4, S_M5, S_FRD, S_FILL,
    S_WAIT, S_SCAN, S_SCMP, S_CRD, S_CWR, S_TOT
  } state_t;

  state_t state_r, state_nxt;
  logic [ADDR_W-1:0]  addr_r, addr_nxt;
  logic [SPACE_W-1:0] space_r, space_nxt;
  logic [TID_W-1:0]   tid_r, tid_nxt;
  logic [31:0]        exp_r, exp_nxt, obs_r, obs_nxt;
  logic               fault_r, fault_nxt, func_r, func_nxt;
  logic [3:0]         limit_r, limit_nxt, woken_r, woken_nxt;
  logic [63:0]        h_r, h_nxt, acc_r, acc_nxt;
  logic [31:0]        t_r, t_nxt;
  logic [BW-1:0]      bucket_r, bucket_nxt, clr_r, clr_nxt;
  logic [FW-1:0]      fill_r, fill_nxt, i_r, i_nxt, j_r, j_nxt, keep_r, keep_nxt;
  logic [SLOTS_PER_BUCKET-1:0] gone_r, gone_nxt;

  logic               out_valid_r, out_valid_nxt, out_last_r, out_last_nxt;
  logic [1:0]         out_kind_r, out_kind_nxt, out_status_r, out_status_nxt;
  logic [15:0]        out_thread_r, out_thread_nxt;
  logic [3:0]         out_total_r, out_total_nxt;

  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;

  logic              fill_we, fill_re;
  logic [BW-1:0]     fill_waddr;
  logic [FW-1:0]     fill_wdata, fill_rdata;
  logic              ent_we, ent_re;
  logic [IW-1:0]     ent_waddr, ent_raddr;
  logic [ENTRY_W-1:0] ent_wdata, ent_rdata;

  logic          out_free, match;
  logic [SW-1:0] scan_slot, cmp_slot;
  logic [15:0]   lim_in;

  function automatic logic [IW-1:0] entry_idx(input logic [BW-1:0] b, input logic [FW-1:0] s);
    entry_idx = IW'(IW'(b) * IW'(SLOTS_PER_BUCKET) + IW'(s));
  endfunction

  fwq_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p_r(mul_p));

  fwq_ram #(.WIDTH(FW), .DEPTH(HASH_BUCKETS)) u_fill_ram (
    .clk(clk), .we(fill_we), .waddr(fill_waddr), .wdata(fill_wdata),
    .re(fill_re), .raddr(bucket_r), .rdata_r(fill_rdata)
  );

  fwq_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_entry_ram (
    .clk(clk), .we(ent_we), .waddr(ent_waddr), .wdata(ent_wdata),
    .re(ent_re), .raddr(ent_raddr), .rdata_r(ent_rdata)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {2'b00, out_total_r, out_thread_r, out_status_r};

  assign out_free  = !out_valid_r || out_tready;
  assign scan_slot = SW'(i_r - FW'(1));
  assign cmp_slot  = SW'(j_r);
  assign match     = (ent_rdata[ADDR_W-1:0] == addr_r) &&
                     (ent_rdata[ADDR_W+SPACE_W-1:ADDR_W] == space_r);
  assign lim_in    = in_tdata[212:197];

  always_comb begin
    state_nxt = state_r;
    addr_nxt = addr_r; space_nxt = space_r; tid_nxt = tid_r;
    exp_nxt = exp_r; obs_nxt = obs_r; fault_nxt = fault_r; func_nxt = func_r;
    limit_nxt = limit_r; woken_nxt = woken_r;
    h_nxt = h_r; acc_nxt = acc_r; t_nxt = t_r;
    bucket_nxt = bucket_r; clr_nxt = clr_r;
    fill_nxt = fill_r; i_nxt = i_r; j_nxt = j_r; keep_nxt = keep_r;
    gone_nxt = gone_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_last_nxt = out_last_r; out_kind_nxt = out_kind_r;
    out_status_nxt = out_status_r; out_thread_nxt = out_thread_r;
    out_total_nxt = out_total_r;
    mul_a = h_r[31:0]; mul_b = FNV_P_LO;
    fill_we = 1'b0; fill_re = 1'b0; fill_waddr = bucket_r; fill_wdata = '0;
    ent_we = 1'b0; ent_re = 1'b0;
    ent_waddr = entry_idx(bucket_r, fill_r);
    ent_wdata = {tid_r, space_r, addr_r};
    ent_raddr = entry_idx(bucket_r, FW'(scan_slot));
    unique case (state_r)
      S_CLR: begin
        fill_we = 1'b1; fill_waddr = clr_r;
        clr_nxt = clr_r + BW'(1);
        if (clr_r == BW'(HASH_BUCKETS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          func_nxt  = in_tuser;
          addr_nxt  = in_tdata[63:0];
          space_nxt = in_tdata[115:64];
          tid_nxt   = in_tdata[131:116];
          exp_nxt   = in_tdata[163:132];
          obs_nxt   = in_tdata[195:164];
          fault_nxt = in_tdata[196];
          limit_nxt = (lim_in > 16'(WOKEN_CAP)) ? 4'(WOKEN_CAP) : lim_in[3:0];
          h_nxt     = FNV_BASIS ^ {12'd0, in_tdata[115:64]};
          state_nxt = S_H0;
        end
      end
      S_H0: state_nxt = S_M1;
      S_M1: begin
        mul_a = h_r[63:32]; acc_nxt = mul_p; state_nxt = S_M2;
      end
      S_M2: begin
        mul_b = FNV_P_HI; t_nxt = mul_p[31:0]; state_nxt = S_M3;
      end
      S_M3: begin
        h_nxt = (acc_r + {t_r + mul_p[31:0], 32'd0}) ^ addr_r;
        state_nxt = S_M4;
      end
      S_M4: state_nxt = S_M5;
      S_M5: begin
        bucket_nxt = BW'(mul_p & 64'(HASH_BUCKETS - 1));
        state_nxt = S_FRD;
      end
      S_FRD: begin
        fill_re = 1'b1; state_nxt = S_FILL;
      end
      S_FILL: begin
        fill_nxt = (fill_rdata > FW'(SLOTS_PER_BUCKET)) ? FW'(SLOTS_PER_BUCKET) : fill_rdata;
        i_nxt = fill_nxt; j_nxt = '0; keep_nxt = '0;
        woken_nxt = '0; gone_nxt = '0;
        state_nxt = func_r ? S_SCAN : S_WAIT;
      end
      S_WAIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1; out_last_nxt = 1'b1; out_kind_nxt = KIND_STATUS;
          out_thread_nxt = '0; out_total_nxt = '0;
          if (fault_r) begin
            out_status_nxt = WS_FAULT;
          end else if (obs_r != exp_r) begin
            out_status_nxt = WS_MISMATCH;
          end else if (fill_r >= FW'(SLOTS_PER_BUCKET)) begin
            out_status_nxt = WS_NOROOM;
          end else begin
            out_status_nxt = WS_BLOCKED;
            ent_we = 1'b1;
            fill_we = 1'b1; fill_wdata = fill_r + FW'(1);
          end
          state_nxt = S_IDLE;
        end
      end
      S_SCAN: begin
        if (i_r == '0 || woken_r == limit_r) begin
          state_nxt = S_CRD;
        end else begin
          ent_re = 1'b1; state_nxt = S_SCMP;
        end
      end
      S_SCMP: begin
        if (!match) begin
          i_nxt = i_r - FW'(1); state_nxt = S_SCAN;
        end else if (out_free) begin
          out_valid_nxt = 1'b1; out_last_nxt = 1'b0; out_kind_nxt = KIND_WOKEN;
          out_status_nxt = WS_BLOCKED; out_total_nxt = '0;
          out_thread_nxt = ent_rdata[ENTRY_W-1:ADDR_W+SPACE_W];
          gone_nxt[scan_slot] = 1'b1;
          woken_nxt = woken_r + 4'd1;
          i_nxt = i_r - FW'(1); state_nxt = S_SCAN;
        end
      end
      S_CRD: begin
        ent_raddr = entry_idx(bucket_r, j_r);
        if (j_r == fill_r) begin
          state_nxt = S_TOT;
        end else begin
          ent_re = 1'b1; state_nxt = S_CWR;
        end
      end
      S_CWR: begin
        ent_waddr = entry_idx(bucket_r, keep_r);
        ent_wdata = ent_rdata;
        if (!gone_r[cmp_slot]) begin
          ent_we = 1'b1; keep_nxt = keep_r + FW'(1);
        end
        j_nxt = j_r + FW'(1); state_nxt = S_CRD;
      end
      S_TOT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1; out_last_nxt = 1'b1; out_kind_nxt = KIND_TOTAL;
          out_status_nxt = WS_BLOCKED; out_thread_nxt = '0; out_total_nxt = woken_r;
          fill_we = 1'b1; fill_wdata = keep_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    addr_r <= addr_nxt; space_r <= space_nxt; tid_r <= tid_nxt;
    exp_r <= exp_nxt; obs_r <= obs_nxt; fault_r <= fault_nxt; func_r <= func_nxt;
    limit_r <= limit_nxt; woken_r <= woken_nxt;
    h_r <= h_nxt; acc_r <= acc_nxt; t_r <= t_nxt;
    bucket_r <= bucket_nxt; fill_r <= fill_nxt;
    i_r <= i_nxt; j_r <= j_nxt; keep_r <= keep_nxt; gone_r <= gone_nxt;
    out_last_r <= out_last_nxt; out_kind_r <= out_kind_nxt;
    out_status_r <= out_status_nxt; out_thread_r <= out_thread_nxt;
    out_total_r <= out_total_nxt;
  end

endmodule

`default_nettype wire

// ===== sv/fwq_ram.sv =====
// generic single write, single read ram with registered read data
// no dependencies
`default_nettype none

module fwq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic                                  re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/fwq_mul.sv =====
// shared 32 by 32 multiplier with registered product for the bucket hash
// no dependencies
`default_nettype none

module fwq_mul (
  input  wire logic        clk,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output logic      [63:0] p_r
);

  always_ff @(posedge clk) begin
    p_r <= 64'(a) * 64'(b);
  end

endmodule

`default_nettype wire

// ===== sv/fwq_checker.sv =====
// port-level checker of the futex wait queue core, bound to the top level
// depends on fwq_pkg and futex_wait_queue_table_core_macros.svh
`default_nettype none

`include "futex_wait_queue_table_core_macros.svh"

module fwq_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_tvalid,
  input wire logic       in_tready,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic [1:0] out_tuser,
  input wire logic       out_tlast
);

  import fwq_pkg::*;

  `FWQ_ASSERT_IMPL(a_kind_legal, out_tvalid, out_tuser <= KIND_TOTAL)
  `FWQ_ASSERT_IMPL(a_woken_not_last, out_tvalid && out_tuser == KIND_WOKEN, !out_tlast)
  `FWQ_ASSERT_IMPL(a_end_is_last, out_tvalid && out_tuser != KIND_WOKEN, out_tlast)
  `FWQ_ASSERT_NEXT(a_busy_after_take, in_tvalid && in_tready, !in_tready)
  `FWQ_ASSERT_NEXT(a_out_holds, out_tvalid && !out_tready, out_tvalid)

endmodule

bind futex_wait_queue_table_core fwq_checker u_fwq_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tuser(out_tuser),
  .out_tlast(out_tlast)
);

`default_nettype wire
